/* rtl/core/mlprq_pkg.sv */
// Shared types, constants and command codes for the multilevel priority ready queue.
`default_nettype none
package mlprq_pkg;
   localparam int MAX_LEVELS_DEF      = 8;
   localparam int SLOTS_PER_LEVEL_DEF = 16;
   localparam int PID_BITS_DEF        = 16;
   localparam logic [3:0] NUM_LEVELS_RESET = 4'd8;
   localparam int CMDQ_DEPTH = 2;

   typedef enum logic [2:0] {
      CMD_INSERT  = 3'd0,
      CMD_REMOVE  = 3'd1,
      CMD_FIND    = 3'd2,
      CMD_HIGHEST = 3'd3,
      CMD_LVL_CNT = 3'd4,
      CMD_TOT_CNT = 3'd5,
      CMD_RSVD6   = 3'd6,
      CMD_RSVD7   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_RANGE    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] pid;
      logic [2:0]  level;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_pid;
      logic [2:0]  result_level;
      logic [7:0]  count;
   } rsp_type;
endpackage
`default_nettype wire

/* rtl/core/mlprq_front.sv */
// Front end: a short command queue; commands pass into it unchanged.
`default_nettype none
module mlprq_front import mlprq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         cmd_valid,
   input  wire logic    cmd_take,
   output req_type      cmd_data
);
   localparam int PW = $clog2(CMDQ_DEPTH);

   req_type        q_ff [CMDQ_DEPTH];
   logic [PW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]    cnt_ff, cnt_in;
   logic           push, pop;
   req_type        clean;

   // unknown commands are kept; pid and level pass unchanged
   always_comb begin
      clean = req_data;
   end

   assign req_stall = (cnt_ff == (PW+1)'(CMDQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + PW'(1) : wp_ff;
      rp_in  = pop  ? rp_ff + PW'(1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= clean;
   end
endmodule
`default_nettype wire

/* rtl/core/mlprq_back.sv */
// Back end: level queues in a slot memory, scan/shift sequencer and response register.
`default_nettype none
module mlprq_back import mlprq_pkg::*; #(
   parameter int MAX_LEVELS      = MAX_LEVELS_DEF,
   parameter int SLOTS_PER_LEVEL = SLOTS_PER_LEVEL_DEF,
   parameter int PID_BITS        = PID_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [3:0] num_levels,
   input  wire logic       cmd_valid,
   output logic            cmd_take,
   input  wire req_type    cmd_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data
);
   localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int SW    = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
   localparam int FW    = $clog2(SLOTS_PER_LEVEL + 1);
   localparam int DEPTH = MAX_LEVELS * SLOTS_PER_LEVEL;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(MAX_LEVELS + 1);
   localparam int TW    = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR, S_HEAD_RD, S_HEAD_WT, S_RESP
   } state_type;

   state_type          state_ff;
   logic [PID_BITS-1:0] mem [DEPTH];
   logic [PID_BITS-1:0] rd_ff;
   logic [FW-1:0]      fill_ff [MAX_LEVELS];
   req_type            cur_ff;
   logic [LW-1:0]      lvl_ff;
   logic [SW-1:0]      pos_ff;
   logic [TW-1:0]      tot_ff;
   logic [NW-1:0]      n_eff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   logic [PID_BITS-1:0] key;

   // effective level count, saturated at MAX_LEVELS
   assign n_eff = (32'(num_levels) > MAX_LEVELS) ? NW'(MAX_LEVELS) : NW'(num_levels);
   assign key       = PID_BITS'(cur_ff.pid);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cmd_take  = (state_ff == S_IDLE) && !rsp_valid_ff;

   function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [SW-1:0] p);
      addr = AW'(32'(l) * SLOTS_PER_LEVEL + 32'(p));
   endfunction

   function automatic rsp_type make_rsp(input status_type s, input logic [7:0] c);
      make_rsp        = '0;
      make_rsp.status = s;
      make_rsp.count  = c;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) fill_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && !rsp_valid_ff) begin
                  cur_ff <= cmd_data;
                  pos_ff <= '0;
                  tot_ff <= '0;
                  lvl_ff <= (cmd_type'(cmd_data.cmd) == CMD_HIGHEST) ?
                            LW'(n_eff - NW'(1)) : '0;
                  unique case (cmd_type'(cmd_data.cmd))
                     CMD_INSERT: begin
                        if (32'(cmd_data.level) >= 32'(n_eff))
                           rsp_ff <= make_rsp(ST_RANGE, '0);
                        else if (fill_ff[LW'(cmd_data.level)] >= FW'(SLOTS_PER_LEVEL))
                           rsp_ff <= make_rsp(ST_FULL, '0);
                        else begin
                           rsp_ff <= make_rsp(ST_OK, '0);
                           mem[addr(LW'(cmd_data.level),
                                SW'(fill_ff[LW'(cmd_data.level)]))] <=
                              PID_BITS'(cmd_data.pid);
                           fill_ff[LW'(cmd_data.level)] <=
                              fill_ff[LW'(cmd_data.level)] + FW'(1);
                        end
                        state_ff <= S_RESP;
                     end
                     CMD_REMOVE, CMD_FIND: begin
                        if (n_eff == '0) begin
                           rsp_ff   <= make_rsp(ST_NOTFOUND, '0);
                           state_ff <= S_RESP;
                        end else begin
                           rsp_ff   <= make_rsp(ST_OK, '0);
                           state_ff <= S_SCAN_RD;
                        end
                     end
                     CMD_HIGHEST: begin
                        if (n_eff == '0) begin
                           rsp_ff   <= make_rsp(ST_NOTFOUND, '0);
                           state_ff <= S_RESP;
                        end else begin
                           rsp_ff   <= make_rsp(ST_OK, '0);
                           state_ff <= S_HEAD_RD;
                        end
                     end
                     CMD_LVL_CNT: begin
                        if (32'(cmd_data.level) >= 32'(n_eff))
                           rsp_ff <= make_rsp(ST_RANGE, '0);
                        else
                           rsp_ff <= make_rsp(ST_OK, 8'(fill_ff[LW'(cmd_data.level)]));
                        state_ff <= S_RESP;
                     end
                     CMD_TOT_CNT: begin
                        rsp_ff <= make_rsp(ST_OK, '0);
                        if (n_eff == '0) state_ff <= S_RESP;
                        else state_ff <= S_HEAD_WT;
                     end
                     default: begin
                        rsp_ff   <= make_rsp(ST_OK, '0);
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            // each slot is read, then compared with the key; empty levels are skipped
            S_SCAN_RD: begin
               if (32'(pos_ff) >= 32'(fill_ff[lvl_ff])) begin
                  pos_ff <= '0;
                  if (32'(lvl_ff) + 1 >= 32'(n_eff)) begin
                     rsp_ff.status <= ST_NOTFOUND;
                     state_ff <= S_RESP;
                  end else lvl_ff <= lvl_ff + LW'(1);
               end else begin
                  rd_ff    <= mem[addr(lvl_ff, pos_ff)];
                  state_ff <= S_SCAN_CMP;
               end
            end
            S_SCAN_CMP: begin
               if (rd_ff == key) begin
                  rsp_ff.result_level <= 3'(lvl_ff);
                  if (cmd_type'(cur_ff.cmd) == CMD_REMOVE) state_ff <= S_SHIFT_RD;
                  else state_ff <= S_RESP;
               end else begin
                  if (32'(pos_ff) + 1 >= 32'(fill_ff[lvl_ff])) begin
                     pos_ff <= '0;
                     if (32'(lvl_ff) + 1 >= 32'(n_eff)) begin
                        rsp_ff.status <= ST_NOTFOUND;
                        state_ff <= S_RESP;
                     end else begin
                        lvl_ff   <= lvl_ff + LW'(1);
                        state_ff <= S_SCAN_RD;
                     end
                  end else begin
                     pos_ff   <= pos_ff + SW'(1);
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            // close the gap: slot[pos] <= slot[pos+1]
            S_SHIFT_RD: begin
               if (32'(pos_ff) + 1 >= 32'(fill_ff[lvl_ff])) begin
                  fill_ff[lvl_ff] <= fill_ff[lvl_ff] - FW'(1);
                  state_ff <= S_RESP;
               end else begin
                  rd_ff    <= mem[addr(lvl_ff, pos_ff + SW'(1))];
                  state_ff <= S_SHIFT_WR;
               end
            end
            S_SHIFT_WR: begin
               mem[addr(lvl_ff, pos_ff)] <= rd_ff;
               pos_ff   <= pos_ff + SW'(1);
               state_ff <= S_SHIFT_RD;
            end
            // walk levels downward to the first non-empty one
            S_HEAD_RD: begin
               if (fill_ff[lvl_ff] != '0) begin
                  rd_ff    <= mem[addr(lvl_ff, '0)];
                  rsp_ff.result_level <= 3'(lvl_ff);
                  state_ff <= S_RESP;
               end else if (lvl_ff == '0) begin
                  rsp_ff.status <= ST_NOTFOUND;
                  state_ff <= S_RESP;
               end else lvl_ff <= lvl_ff - LW'(1);
            end
            // total count: one level added per cycle
            S_HEAD_WT: begin
               tot_ff <= tot_ff + TW'(fill_ff[lvl_ff]);
               if (32'(lvl_ff) + 1 >= 32'(n_eff)) begin
                  rsp_ff.count <= 8'(tot_ff + TW'(fill_ff[lvl_ff]));
                  state_ff <= S_RESP;
               end else lvl_ff <= lvl_ff + LW'(1);
            end
            S_RESP: begin
               if (cmd_type'(cur_ff.cmd) == CMD_HIGHEST && rsp_ff.status == ST_OK)
                  rsp_ff.result_pid <= 16'(rd_ff);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/core/multilevel_priority_ready_queue.sv */
// Top level of the multilevel priority ready queue.
// Usage:
//   req_valid/req_stall/req_data carry one command transaction (cmd, pid, level).
//   rsp_valid/rsp_stall/rsp_data return exactly one response transaction per command.
//   csr_we/csr_wdata write num_levels (levels in use); write only while idle.
// Sequencing (from acceptance to response valid):
//   insert and level count go straight to the response; highest walks down the
//   levels in use to the first non-empty one; total count sums the levels in use;
//   find reads and compares each slot in turn, skipping empty levels; remove then
//   shifts each later entry of that level down. The slot memory is single-port.
//   A two-entry command queue between front and back accepts new commands
//   while the back end works or a response waits.
// Reset: all levels empty, num_levels = 8. Slot memory is not cleared; only
//   entries below a level's fill are read.
// Stall: a held response keeps its payload and the back end waits; once the
//   command queue fills, req_stall rises.
`default_nettype none
module multilevel_priority_ready_queue import mlprq_pkg::*; #(
   parameter int MAX_LEVELS      = MAX_LEVELS_DEF,
   parameter int SLOTS_PER_LEVEL = SLOTS_PER_LEVEL_DEF,
   parameter int PID_BITS        = PID_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic [3:0] csr_wdata
);
   logic [3:0] num_levels_ff;
   logic       cmd_valid, cmd_take;
   req_type    cmd_data;

   always_ff @(posedge clock) begin
      if (reset) num_levels_ff <= NUM_LEVELS_RESET;
      else if (csr_we) num_levels_ff <= csr_wdata;
   end

   mlprq_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   mlprq_back #(
      .MAX_LEVELS(MAX_LEVELS), .SLOTS_PER_LEVEL(SLOTS_PER_LEVEL), .PID_BITS(PID_BITS)
   ) u_back (
      .clock, .reset, .num_levels(num_levels_ff), .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire

/* tb/mlprq_checker.sv */
// Scoreboard for the multilevel priority ready queue: predicts and checks every response.
module mlprq_checker import mlprq_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire req_type    req_data,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire rsp_type    rsp_data,
   input  wire logic       csr_we,
   input  wire logic [3:0] csr_wdata,
   output int              fail_count,
   output int              pending_count
);
   localparam int NLV = MAX_LEVELS_DEF;
   localparam int NSL = SLOTS_PER_LEVEL_DEF;

   logic [15:0] queue_pids [NLV][NSL];
   int          queue_fill [NLV];
   logic [3:0]  level_reg;
   rsp_type     expected_rsps [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      fail_count++;
   endtask

   function automatic rsp_type queue_apply(input req_type r);
      rsp_type o;
      int n, l, i, hit_l, hit_p;
      o = '0;
      n = (level_reg > NLV) ? NLV : level_reg;
      hit_l = -1;
      hit_p = 0;
      if (r.cmd == CMD_REMOVE || r.cmd == CMD_FIND)
         for (l = 0; l < n && hit_l < 0; l++)
            for (i = 0; i < queue_fill[l] && hit_l < 0; i++)
               if (queue_pids[l][i] == r.pid) begin
                  hit_l = l;
                  hit_p = i;
               end
      case (cmd_type'(r.cmd))
         CMD_INSERT: begin
            if (r.level >= n) o.status = ST_RANGE;
            else if (queue_fill[r.level] >= NSL) o.status = ST_FULL;
            else begin
               queue_pids[r.level][queue_fill[r.level]] = r.pid;
               queue_fill[r.level]++;
            end
         end
         CMD_REMOVE, CMD_FIND: begin
            if (hit_l < 0) o.status = ST_NOTFOUND;
            else begin
               o.result_level = 3'(hit_l);
               if (r.cmd == CMD_REMOVE) begin
                  for (i = hit_p; i + 1 < queue_fill[hit_l]; i++)
                     queue_pids[hit_l][i] = queue_pids[hit_l][i + 1];
                  queue_fill[hit_l]--;
               end
            end
         end
         CMD_HIGHEST: begin
            o.status = ST_NOTFOUND;
            for (l = n - 1; l >= 0; l--)
               if (queue_fill[l] != 0) begin
                  o.status = ST_OK;
                  o.result_pid = queue_pids[l][0];
                  o.result_level = 3'(l);
                  break;
               end
         end
         CMD_LVL_CNT: begin
            if (r.level >= n) o.status = ST_RANGE;
            else o.count = 8'(queue_fill[r.level]);
         end
         CMD_TOT_CNT: begin
            for (l = 0; l < n; l++) o.count = o.count + 8'(queue_fill[l]);
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int l = 0; l < NLV; l++) queue_fill[l] = 0;
         level_reg = NUM_LEVELS_RESET;
         expected_rsps.delete();
      end else begin
         if (csr_we) level_reg = csr_wdata;
         if (req_valid && !req_stall)
            expected_rsps.insert(expected_rsps.size(), queue_apply(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response transaction", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.result_pid != want.result_pid)
                  report_mismatch("result_pid", rsp_data.result_pid, want.result_pid);
               if (rsp_data.result_level != want.result_level)
                  report_mismatch("result_level", rsp_data.result_level,
                                  want.result_level);
               if (rsp_data.count != want.count)
                  report_mismatch("count", rsp_data.count, want.count);
            end
         end
      end
      pending_count = expected_rsps.size();
   end
endmodule

/* tb/tb_multilevel_priority_ready_queue.sv */
// Stimulus and verdict for the multilevel priority ready queue.
module tb_multilevel_priority_ready_queue;
   import mlprq_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   rsp_type    rsp_data;
   logic       csr_we = 0;
   logic [3:0] csr_wdata = '0;
   int         fail_count, pending_count;
   int         cycle_count = 0;
   // small pool of pids so remove/find hit often and duplicates appear
   logic [15:0] pid_pool [8];

   always #6 clock = ~clock;

   multilevel_priority_ready_queue dut (.*);

   mlprq_checker checker_i (.*);

   // Watchdog: ends the run with FAILURE once cycle_count passes its limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response side: random stall before each transaction, with calm stretches.
   initial begin
      int waits;
      forever begin
         @(negedge clock);
         waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (waits != 0) begin
            rsp_stall <= 1;
            repeat (waits) @(negedge clock);
         end
         rsp_stall <= 0;
         // hold low until one transaction is taken
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // Drive one command transaction; valid stays high until accepted.
   task automatic send_cmd(input cmd_type c, input logic [15:0] p, input logic [2:0] l,
                           input int gap);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_data <= '{cmd: c, pid: p, level: l};
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait until every response is back, then let the back end settle.
   task automatic drain_queue();
      @(negedge clock);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_levels(input logic [3:0] v);
      drain_queue();
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic int draw_gap();
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
   endfunction

   task automatic random_phase(input int items);
      cmd_type c;
      logic [15:0] p;
      for (int k = 0; k < items; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: c = CMD_INSERT;
            4, 5:       c = CMD_REMOVE;
            6:          c = CMD_FIND;
            7:          c = CMD_HIGHEST;
            8:          c = ($urandom_range(0, 1) == 0) ? CMD_LVL_CNT : CMD_TOT_CNT;
            default:    c = cmd_type'($urandom_range(0, 7));
         endcase
         p = ($urandom_range(0, 4) == 0) ? 16'($urandom) : pid_pool[$urandom_range(0, 7)];
         send_cmd(c, p, 3'($urandom_range(0, 7)), draw_gap());
      end
   endtask

   initial begin
      foreach (pid_pool[i]) pid_pool[i] = 16'($urandom);
      pid_pool[0] = 16'h0000;
      pid_pool[1] = 16'hffff;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty queue, field extremes, duplicates, fill one level, odd codes
      send_cmd(CMD_HIGHEST, 16'h0, 3'd0, 0);
      send_cmd(CMD_FIND, 16'hffff, 3'd0, 0);
      send_cmd(CMD_REMOVE, 16'h0, 3'd0, 0);
      send_cmd(CMD_TOT_CNT, 16'h0, 3'd0, 0);
      send_cmd(CMD_INSERT, 16'hffff, 3'd7, 0);
      send_cmd(CMD_INSERT, 16'h0000, 3'd0, 0);
      send_cmd(CMD_INSERT, 16'h0000, 3'd0, 0);
      send_cmd(CMD_FIND, 16'h0000, 3'd0, 0);
      send_cmd(CMD_HIGHEST, 16'h0, 3'd0, 0);
      send_cmd(CMD_RSVD6, 16'h1234, 3'd5, 0);
      send_cmd(CMD_RSVD7, 16'hffff, 3'd7, 0);
      for (int i = 0; i < 17; i++) send_cmd(CMD_INSERT, 16'(i + 100), 3'd3, 0);
      send_cmd(CMD_LVL_CNT, 16'h0, 3'd3, 0);
      send_cmd(CMD_REMOVE, 16'd105, 3'd0, 0);
      send_cmd(CMD_LVL_CNT, 16'h0, 3'd7, 0);
      send_cmd(CMD_TOT_CNT, 16'h0, 3'd0, 0);

      // hide upper levels, then zero levels, then saturate above the maximum
      write_levels(4'd3);
      send_cmd(CMD_HIGHEST, 16'h0, 3'd0, 0);
      send_cmd(CMD_INSERT, 16'h55aa, 3'd3, 0);
      send_cmd(CMD_LVL_CNT, 16'h0, 3'd4, 0);
      random_phase(100);
      write_levels(4'd0);
      send_cmd(CMD_INSERT, 16'h1, 3'd0, 0);
      send_cmd(CMD_FIND, 16'h0, 3'd0, 0);
      send_cmd(CMD_TOT_CNT, 16'h0, 3'd0, 0);
      random_phase(20);
      write_levels(4'd15);
      random_phase(200);
      write_levels(4'd1);
      random_phase(80);
      write_levels(4'd8);
      random_phase(200);

      drain_queue();
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/mlprq_pkg.sv
rtl/core/mlprq_front.sv
rtl/core/mlprq_back.sv
rtl/core/multilevel_priority_ready_queue.sv
tb/mlprq_checker.sv
tb/tb_multilevel_priority_ready_queue.sv
